### hdl/bgmc_pkg.sv
// shared types, codes and constants of the button gesture mode controller
`default_nettype none
package bgmc_pkg;

  // default width of the click and hold age counters
  localparam int AGE_WIDTH_DEF = 16;

  // configuration register widths and reset values
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_DATA_W-1:0] DCW_RESET  = 16'd400;
  localparam logic [CFG_DATA_W-1:0] HOLD_RESET = 16'd700;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME           = 1'b1;

  // light modes
  typedef enum logic [1:0] {
    LIGHT_OFF      = 2'd0,
    LIGHT_SPA      = 2'd1,
    LIGHT_SHOWCASE = 2'd2,
    LIGHT_CANVAS   = 2'd3
  } mode_t;

  // reported events
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACK      = 3'd1,
    EV_SHUTDOWN = 3'd2,
    EV_CYCLED   = 3'd3,
    EV_AON_ON   = 3'd4,
    EV_AON_OFF  = 3'd5
  } event_t;

  // configuration registers as seen by the gesture logic
  typedef struct packed {
    logic [CFG_DATA_W-1:0] double_click_window;
    logic [CFG_DATA_W-1:0] hold_time;
  } cfg_t;

  // one result item
  typedef struct packed {
    event_t event_code;
    logic   always_on_flag;
    mode_t  light_mode;
  } result_t;

  // mode sequence on an expired single click
  function automatic mode_t next_mode(input mode_t m);
    mode_t r;
    case (m)
      LIGHT_OFF:      r = LIGHT_SPA;
      LIGHT_SPA:      r = LIGHT_SHOWCASE;
      LIGHT_SHOWCASE: r = LIGHT_CANVAS;
      LIGHT_CANVAS:   r = LIGHT_SPA;
      default:        r = LIGHT_SPA;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/button_gesture_mode_controller.sv
// top level of the button gesture mode controller: stream ports, config and result register
`default_nettype none
// Takes one tick item per transfer (click event and held level of the mode
// button) and returns exactly one result per tick: the light mode, the
// always-on flag and an event code. Throughput is one item per clock unless
// the result stream stalls: the gesture state is updated in a single pass of
// compare and increment logic and the result lands in one output register,
// valid in the cycle after its tick. A new item is taken whenever that output
// register is empty or its result is being transferred in the same cycle.
// Configuration writes (index 0: double-click window, index 1: hold time,
// both in ticks) are always taken and must be made while no tick is in flight.
module button_gesture_mode_controller
  import bgmc_pkg::*;
#(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] click, [1] held, [7:2] zero
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [1:0] light_mode, [2] always_on_flag,
                                                 // [5:3] event_code, [7:6] zero
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_xfer;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_click_window <= DCW_RESET;
      cfg_r.hold_time           <= HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOUBLE_CLICK_WINDOW: cfg_r.double_click_window <= cfg_data;
        REG_HOLD_TIME:           cfg_r.hold_time           <= cfg_data;
        default:                 cfg_r                     <= cfg_r;
      endcase
    end
  end

  // take a tick when the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  bgmc_core #(
    .AGE_WIDTH(AGE_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_xfer),
    .click   (in_tdata[0]),
    .held    (in_tdata[1]),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.event_code, res_r.always_on_flag, res_r.light_mode};

endmodule
`default_nettype wire

### hdl/bgmc_core.sv
// gesture state registers and the per-tick click, hold and expiry logic
`default_nettype none
module bgmc_core
  import bgmc_pkg::*;
#(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire logic    click,
  input  wire logic    held,
  input  wire cfg_t    cfg,
  output result_t      res_nxt
);

  // compare width covers both the age counters and the 16-bit registers
  localparam int CMP_W = (AGE_WIDTH > CFG_DATA_W) ? AGE_WIDTH : CFG_DATA_W;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  mode_t                mode_r, mode_nxt;
  logic                 pending_r, pending_nxt;
  logic [AGE_WIDTH-1:0] click_age_r, click_age_nxt;
  logic                 hold_active_r, hold_active_nxt;
  logic [AGE_WIDTH-1:0] hold_age_r, hold_age_nxt;
  logic                 hold_done_r, hold_done_nxt;
  logic                 aon_r, aon_nxt;
  event_t               ev;

  // one tick: pending click ages, then click, then hold, then expiry of a pending click
  always_comb begin
    logic [CMP_W-1:0] win;
    logic [CMP_W-1:0] hold_lim;
    win      = CMP_W'(cfg.double_click_window);
    hold_lim = CMP_W'(cfg.hold_time);

    mode_nxt        = mode_r;
    pending_nxt     = pending_r;
    click_age_nxt   = click_age_r;
    hold_active_nxt = hold_active_r;
    hold_age_nxt    = hold_age_r;
    hold_done_nxt   = hold_done_r;
    aon_nxt         = aon_r;
    ev              = EV_NONE;

    // pending click ages, saturating
    if (pending_r && (click_age_r != AGE_MAX)) begin
      click_age_nxt = click_age_r + AGE_WIDTH'(1);
    end

    // click (ignored after a completed hold): double click shuts down, otherwise a new pending click
    if (click && !hold_done_r) begin
      if (pending_r && (CMP_W'(click_age_nxt) <= win)) begin
        pending_nxt = 1'b0;
        mode_nxt    = LIGHT_OFF;
        ev          = EV_SHUTDOWN;
      end else begin
        pending_nxt   = 1'b1;
        click_age_nxt = '0;
        ev            = EV_ACK;
      end
    end

    // hold timer and always-on toggle
    if (held) begin
      if (!hold_active_r) begin
        hold_active_nxt = 1'b1;
        hold_age_nxt    = '0;
      end else begin
        if (hold_age_r != AGE_MAX) begin
          hold_age_nxt = hold_age_r + AGE_WIDTH'(1);
        end
        if (!hold_done_r && (CMP_W'(hold_age_nxt) >= hold_lim)) begin
          hold_done_nxt = 1'b1;
          pending_nxt   = 1'b0;
          aon_nxt       = !aon_r;
          if (!aon_r) begin
            if (mode_nxt == LIGHT_OFF) begin
              mode_nxt = LIGHT_SPA;
            end
            ev = EV_AON_ON;
          end else begin
            ev = EV_AON_OFF;
          end
        end
      end
    end else begin
      hold_active_nxt = 1'b0;
      hold_age_nxt    = '0;
      hold_done_nxt   = 1'b0;
    end

    // window ran out: cycle the mode
    if (pending_nxt && !hold_done_nxt && (CMP_W'(click_age_nxt) > win)) begin
      pending_nxt = 1'b0;
      mode_nxt    = next_mode(mode_nxt);
      ev          = EV_CYCLED;
    end
  end

  // result of this tick
  always_comb begin
    res_nxt.light_mode     = mode_nxt;
    res_nxt.always_on_flag = aon_nxt;
    res_nxt.event_code     = ev;
  end

  // state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= LIGHT_OFF;
      pending_r     <= 1'b0;
      click_age_r   <= '0;
      hold_active_r <= 1'b0;
      hold_age_r    <= '0;
      hold_done_r   <= 1'b0;
      aon_r         <= 1'b0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      pending_r     <= pending_nxt;
      click_age_r   <= click_age_nxt;
      hold_active_r <= hold_active_nxt;
      hold_age_r    <= hold_age_nxt;
      hold_done_r   <= hold_done_nxt;
      aon_r         <= aon_nxt;
    end
  end

endmodule
`default_nettype wire
